// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the lexer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is low.
`define SLLX_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SLLX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sllx_pkg.sv =====
// Shared constants, keyword table and character classes of the source lexer.
package sllx_pkg;

    localparam int KIND_W = 5;
    localparam logic [KIND_W-1:0] KIND_DELIM   = 5'd0;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd1;
    localparam logic [KIND_W-1:0] KIND_PUNCT   = 5'd2;
    localparam logic [KIND_W-1:0] KIND_STRING  = 5'd3;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd4;
    localparam logic [KIND_W-1:0] KIND_KW0     = 5'd5;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd18;

    localparam int MODE_W = 4;
    localparam logic [MODE_W-1:0] M_IDLE  = 4'd0;
    localparam logic [MODE_W-1:0] M_NUM   = 4'd1;
    localparam logic [MODE_W-1:0] M_IDENT = 4'd2;
    localparam logic [MODE_W-1:0] M_STR   = 4'd3;
    localparam logic [MODE_W-1:0] M_BANG  = 4'd4;
    localparam logic [MODE_W-1:0] M_AMP   = 4'd5;
    localparam logic [MODE_W-1:0] M_BAR   = 4'd6;
    localparam logic [MODE_W-1:0] M_LT    = 4'd7;
    localparam logic [MODE_W-1:0] M_GT    = 4'd8;
    localparam logic [MODE_W-1:0] M_MINUS = 4'd9;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    localparam int KW_COUNT = 13;
    localparam int KW_CHARS = 8;
    localparam int KW_BUF_W = 8 * KW_CHARS;

    // Keywords packed first character in the low byte, zero padded.
    localparam logic [KW_BUF_W-1:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_006B_6165_7262,  // break
        64'h6575_6E69_746E_6F63,  // continue
        64'h0000_0000_6669_6C65,  // elif
        64'h0000_0000_6573_6C65,  // else
        64'h0000_0000_0000_6E66,  // fn
        64'h0000_0000_0000_3869,  // i8
        64'h0000_0000_0034_3669,  // i64
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_006C_696E,  // nil
        64'h0000_0000_0070_6572,  // rep
        64'h0000_6E72_7574_6572,  // return
        64'h0000_0000_0000_7473,  // st
        64'h0000_0065_6C69_6877   // while
    };

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F};
    endfunction

    function automatic logic is_single_punct(input logic [7:0] b);
        return b inside {8'h3A, 8'h3B, 8'h7B, 8'h7D, 8'h3D, 8'h2B, 8'h2F, 8'h2A,
                         8'h25, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2E, 8'h2C};
    endfunction

    // Kind of the token held pending in the given mode.
    function automatic logic [KIND_W-1:0] flush_kind(input logic [MODE_W-1:0] mode,
                                                     input logic [KW_BUF_W-1:0] kbuf,
                                                     input logic short_id);
        logic [KIND_W-1:0] k;
        k = KIND_UNKNOWN;
        case (mode)
            M_NUM: begin
                k = KIND_NUMBER;
            end
            M_IDENT: begin
                k = KIND_IDENT;
                if (short_id) begin
                    for (int i = 0; i < KW_COUNT; i++) begin
                        if (kbuf == KW_TEXT[i]) begin
                            k = KIND_KW0 + KIND_W'(i);
                        end
                    end
                end
            end
            M_BANG, M_LT, M_GT, M_MINUS: begin
                k = KIND_PUNCT;
            end
            default: begin
                k = KIND_UNKNOWN;
            end
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/sllx_core.sv =====
// Lexer state and the single-pass logic that turns one byte into up to two tokens.
module sllx_core #(
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 24,
    parameter int OFFSET_BITS = 24,
    localparam int RES_W = sllx_pkg::KIND_W + LENGTH_BITS + LINE_BITS + OFFSET_BITS + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_source_byte,
    input  logic             i_end_of_source,
    output logic [1:0]       o_res_vld,
    output logic [RES_W-1:0] o_res0,
    output logic [RES_W-1:0] o_res1
);

    logic [sllx_pkg::MODE_W-1:0]   r_mode, n_mode;
    logic [LENGTH_BITS-1:0]        r_plen, n_plen;
    logic [LINE_BITS-1:0]          r_pline, n_pline;
    logic [OFFSET_BITS-1:0]        r_poff, n_poff;
    logic [LINE_BITS-1:0]          r_line, n_line;
    logic [OFFSET_BITS-1:0]        r_pos, n_pos;
    logic [sllx_pkg::KW_BUF_W-1:0] r_kbuf, n_kbuf;
    logic                          r_ended, n_ended;

    logic [LENGTH_BITS-1:0] plen_inc;
    logic                   taken, flush_old, fin;
    logic                   a_vld, b_vld, c_vld;
    logic [RES_W-1:0]       a_res, b_res, c_res;
    logic [1:0]             cnt;

    function automatic logic [RES_W-1:0] pack(input logic [sllx_pkg::KIND_W-1:0] kind,
                                              input logic [LENGTH_BITS-1:0] len,
                                              input logic [LINE_BITS-1:0] line,
                                              input logic [OFFSET_BITS-1:0] off);
        return {kind, len, line, off, 1'b0};
    endfunction

    assign plen_inc = (&r_plen) ? r_plen : r_plen + LENGTH_BITS'(1);

    always_comb begin
        n_mode    = r_mode;
        n_plen    = r_plen;
        n_pline   = r_pline;
        n_poff    = r_poff;
        n_line    = r_line;
        n_pos     = r_pos;
        n_kbuf    = r_kbuf;
        n_ended   = r_ended;
        taken     = 1'b0;
        flush_old = 1'b0;
        fin       = 1'b0;
        a_vld     = 1'b0;
        b_vld     = 1'b0;
        c_vld     = 1'b0;
        a_res     = '0;
        b_res     = '0;
        c_res     = '0;
        if (i_fire && !r_ended) begin
            if (i_source_byte == sllx_pkg::CH_NUL) begin
                fin     = 1'b1;
                n_ended = 1'b1;
                c_vld   = (r_mode != sllx_pkg::M_IDLE);
                c_res   = pack(sllx_pkg::flush_kind(r_mode, r_kbuf,
                                   r_plen <= LENGTH_BITS'(sllx_pkg::KW_CHARS)),
                               r_plen, r_pline, r_poff);
                n_mode  = sllx_pkg::M_IDLE;
            end else begin
                case (r_mode)
                    sllx_pkg::M_NUM: begin
                        if (sllx_pkg::is_digit(i_source_byte)) begin
                            taken  = 1'b1;
                            n_plen = plen_inc;
                        end else begin
                            flush_old = 1'b1;
                        end
                    end
                    sllx_pkg::M_IDENT: begin
                        if (sllx_pkg::is_digit(i_source_byte) ||
                            sllx_pkg::is_alpha(i_source_byte)) begin
                            taken = 1'b1;
                            if (r_plen < LENGTH_BITS'(sllx_pkg::KW_CHARS)) begin
                                n_kbuf[{r_plen[2:0], 3'b000} +: 8] = i_source_byte;
                            end
                            n_plen = plen_inc;
                        end else begin
                            flush_old = 1'b1;
                        end
                    end
                    sllx_pkg::M_STR: begin
                        taken  = 1'b1;
                        n_plen = plen_inc;
                        if (i_source_byte == sllx_pkg::CH_QUOTE) begin
                            a_vld  = 1'b1;
                            a_res  = pack(sllx_pkg::KIND_STRING, plen_inc, r_pline, r_poff);
                            n_mode = sllx_pkg::M_IDLE;
                        end
                    end
                    sllx_pkg::M_BANG, sllx_pkg::M_LT, sllx_pkg::M_GT: begin
                        taken     = (i_source_byte == sllx_pkg::CH_EQ);
                        flush_old = !taken;
                    end
                    sllx_pkg::M_AMP: begin
                        taken     = (i_source_byte == sllx_pkg::CH_AMP);
                        flush_old = !taken;
                    end
                    sllx_pkg::M_BAR: begin
                        taken     = (i_source_byte == sllx_pkg::CH_BAR);
                        flush_old = !taken;
                    end
                    sllx_pkg::M_MINUS: begin
                        taken     = (i_source_byte == sllx_pkg::CH_GT);
                        flush_old = !taken;
                    end
                    default: begin
                        taken = 1'b0;
                    end
                endcase

                if (taken && (r_mode inside {sllx_pkg::M_BANG, sllx_pkg::M_AMP,
                                             sllx_pkg::M_BAR, sllx_pkg::M_LT,
                                             sllx_pkg::M_GT, sllx_pkg::M_MINUS})) begin
                    a_vld  = 1'b1;
                    a_res  = pack(sllx_pkg::KIND_PUNCT, LENGTH_BITS'(2), r_pline, r_poff);
                    n_mode = sllx_pkg::M_IDLE;
                end
                if (flush_old) begin
                    a_vld  = 1'b1;
                    a_res  = pack(sllx_pkg::flush_kind(r_mode, r_kbuf,
                                      r_plen <= LENGTH_BITS'(sllx_pkg::KW_CHARS)),
                                  r_plen, r_pline, r_poff);
                    n_mode = sllx_pkg::M_IDLE;
                end

                if (!taken) begin
                    n_plen  = LENGTH_BITS'(1);
                    n_pline = r_line;
                    n_poff  = r_pos;
                    n_kbuf  = '0;
                    if (sllx_pkg::is_digit(i_source_byte)) begin
                        n_mode = sllx_pkg::M_NUM;
                    end else if (sllx_pkg::is_alpha(i_source_byte)) begin
                        n_mode = sllx_pkg::M_IDENT;
                        n_kbuf = sllx_pkg::KW_BUF_W'(i_source_byte);
                    end else if (i_source_byte == sllx_pkg::CH_QUOTE) begin
                        n_mode = sllx_pkg::M_STR;
                    end else if (i_source_byte == sllx_pkg::CH_BANG) begin
                        n_mode = sllx_pkg::M_BANG;
                    end else if (i_source_byte == sllx_pkg::CH_AMP) begin
                        n_mode = sllx_pkg::M_AMP;
                    end else if (i_source_byte == sllx_pkg::CH_BAR) begin
                        n_mode = sllx_pkg::M_BAR;
                    end else if (i_source_byte == sllx_pkg::CH_LT) begin
                        n_mode = sllx_pkg::M_LT;
                    end else if (i_source_byte == sllx_pkg::CH_GT) begin
                        n_mode = sllx_pkg::M_GT;
                    end else if (i_source_byte == sllx_pkg::CH_MINUS) begin
                        n_mode = sllx_pkg::M_MINUS;
                    end else begin
                        n_plen  = r_plen;
                        n_pline = r_pline;
                        n_poff  = r_poff;
                        n_kbuf  = r_kbuf;
                        b_vld   = 1'b1;
                        if (i_source_byte inside {sllx_pkg::CH_NL, sllx_pkg::CH_CR,
                                                  sllx_pkg::CH_SP}) begin
                            b_res = pack(sllx_pkg::KIND_DELIM, LENGTH_BITS'(1), r_line, r_pos);
                        end else if (sllx_pkg::is_single_punct(i_source_byte)) begin
                            b_res = pack(sllx_pkg::KIND_PUNCT, LENGTH_BITS'(1), r_line, r_pos);
                        end else begin
                            b_res = pack(sllx_pkg::KIND_UNKNOWN, LENGTH_BITS'(1), r_line,
                                         r_pos);
                        end
                        if (i_source_byte == sllx_pkg::CH_NL && !(&r_line)) begin
                            n_line = r_line + LINE_BITS'(1);
                        end
                    end
                end

                n_pos = (&r_pos) ? r_pos : r_pos + OFFSET_BITS'(1);

                if (i_end_of_source) begin
                    fin     = 1'b1;
                    n_ended = 1'b1;
                    c_vld   = (n_mode != sllx_pkg::M_IDLE);
                    c_res   = pack(sllx_pkg::flush_kind(n_mode, n_kbuf,
                                       n_plen <= LENGTH_BITS'(sllx_pkg::KW_CHARS)),
                                   n_plen, n_pline, n_poff);
                    n_mode  = sllx_pkg::M_IDLE;
                end
            end
        end
    end

    // At most two of the three candidates are valid; keep their order.
    always_comb begin
        cnt    = 2'({1'b0, a_vld} + {1'b0, b_vld} + {1'b0, c_vld});
        o_res0 = a_vld ? a_res : (b_vld ? b_res : c_res);
        o_res1 = (a_vld && b_vld) ? b_res : c_res;
        o_res0[0] = fin && (cnt == 2'd1);
        o_res1[0] = fin && (cnt == 2'd2);
        o_res_vld = {cnt == 2'd2, cnt != 2'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sllx_pkg::M_IDLE;
            r_plen  <= '0;
            r_pline <= LINE_BITS'(1);
            r_poff  <= '0;
            r_line  <= LINE_BITS'(1);
            r_pos   <= '0;
            r_kbuf  <= '0;
            r_ended <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_plen  <= n_plen;
            r_pline <= n_pline;
            r_poff  <= n_poff;
            r_line  <= n_line;
            r_pos   <= n_pos;
            r_kbuf  <= n_kbuf;
            r_ended <= n_ended;
        end
    end

endmodule

// ===== rtl/sllx_fifo.sv =====
// Small token queue that takes up to two entries per cycle and gives one.
module sllx_fifo #(
    parameter int WIDTH = 70
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push,
    input  logic [WIDTH-1:0] i_data0,
    input  logic [WIDTH-1:0] i_data1,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]                r_mem [sllx_pkg::FIFO_DEPTH];
    logic [sllx_pkg::FIFO_PTR_W-1:0] r_wp, n_wp;
    logic [sllx_pkg::FIFO_PTR_W-1:0] r_rp, n_rp;
    logic [sllx_pkg::FIFO_CNT_W-1:0] r_cnt, n_cnt;
    logic                            pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_space = (r_cnt <= sllx_pkg::FIFO_CNT_W'(sllx_pkg::FIFO_DEPTH - 2));
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wp  = r_wp + sllx_pkg::FIFO_PTR_W'({1'b0, i_push[0]} + {1'b0, i_push[1]});
        n_rp  = r_rp + sllx_pkg::FIFO_PTR_W'(pop);
        n_cnt = r_cnt + sllx_pkg::FIFO_CNT_W'({1'b0, i_push[0]} + {1'b0, i_push[1]})
                - sllx_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push[0]) begin
            r_mem[r_wp] <= i_data0;
        end
        if (i_push[1]) begin
            r_mem[r_wp + sllx_pkg::FIFO_PTR_W'(1)] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/source_lexer_byte_stream.sv =====
// Top level of the streaming source lexer: one source byte in, tokens out.
// A token enters the token queue as the byte that completes it is taken, and shows from the queue's head.
// Throughput: one byte per cycle while the four-entry token queue has room for two.
// A byte that yields two tokens adds two queue entries, which drain at one per cycle while the output is ready.
// Reset (synchronous, active low) returns the lexer to line 1, offset 0, empty queue.
module source_lexer_byte_stream #(
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 24,
    parameter int OFFSET_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_source_byte,
    input  logic                        i_end_of_source,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [sllx_pkg::KIND_W-1:0] o_token_kind,
    output logic [LENGTH_BITS-1:0]      o_token_length,
    output logic [LINE_BITS-1:0]        o_start_line,
    output logic [OFFSET_BITS-1:0]      o_start_offset,
    output logic                        o_final_token
);

    localparam int RES_W = sllx_pkg::KIND_W + LENGTH_BITS + LINE_BITS + OFFSET_BITS + 1;

    logic [1:0]       res_vld;
    logic [RES_W-1:0] res0, res1, head;
    logic             fire;

    assign fire = i_in_valid && o_in_ready;

    sllx_core #(
        .LENGTH_BITS (LENGTH_BITS),
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_source_byte   (i_source_byte),
        .i_end_of_source (i_end_of_source),
        .o_res_vld       (res_vld),
        .o_res0          (res0),
        .o_res1          (res1)
    );

    sllx_fifo #(
        .WIDTH (RES_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_data0 (res0),
        .i_data1 (res1),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (head)
    );

    assign o_final_token  = head[0];
    assign o_start_offset = head[OFFSET_BITS:1];
    assign o_start_line   = head[OFFSET_BITS+LINE_BITS:OFFSET_BITS+1];
    assign o_token_length = head[OFFSET_BITS+LINE_BITS+LENGTH_BITS:OFFSET_BITS+LINE_BITS+1];
    assign o_token_kind   = head[RES_W-1:RES_W-sllx_pkg::KIND_W];

endmodule

// ===== rtl/sllx_chk.sv =====
// Port-level checker for the source lexer, bound to the top level.
`include "assert_macros.svh"

module sllx_chk #(
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 24,
    parameter int OFFSET_BITS = 24
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [sllx_pkg::KIND_W-1:0] o_token_kind,
    input logic [LENGTH_BITS-1:0]      o_token_length,
    input logic [LINE_BITS-1:0]        o_start_line,
    input logic [OFFSET_BITS-1:0]      o_start_offset,
    input logic                        o_final_token
);

    // A stalled token holds until its transfer.
    `SLLX_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_token_length) && $stable(o_start_line) && $stable(o_start_offset) && $stable(o_token_kind) && $stable(o_final_token), "token changed while stalled")

    // Nothing follows the final token until reset.
    `SLLX_ASSERT_RST(a_final_last, i_clk, i_rst_n, o_out_valid && i_out_ready && o_final_token |=> !o_out_valid, "token after final token")

    // Reset empties the token queue.
    `SLLX_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "token shown right after reset")

    `SLLX_ASSERT_RST(a_len_line, i_clk, i_rst_n, o_out_valid |-> o_token_length != '0 && o_start_line != '0, "zero length or zero line")

    // Delimiters are one byte; punctuators are one or two.
    `SLLX_ASSERT_RST(a_short_kinds, i_clk, i_rst_n, o_out_valid && (o_token_kind == sllx_pkg::KIND_DELIM || o_token_kind == sllx_pkg::KIND_PUNCT) |-> o_token_length == LENGTH_BITS'(1) || (o_token_kind == sllx_pkg::KIND_PUNCT && o_token_length == LENGTH_BITS'(2)), "bad delimiter or punctuator length")

endmodule

bind source_lexer_byte_stream sllx_chk #(
    .LENGTH_BITS (LENGTH_BITS),
    .LINE_BITS   (LINE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
) u_sllx_chk (.*);

// ===== tb/tb_source_lexer_byte_stream.sv =====
// Self-checking testbench for the streaming source lexer, with its own token predictor.
module tb_source_lexer_byte_stream;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_W  = 16;
    localparam int LINE_W = 24;
    localparam int OFFS_W = 24;
    localparam int LONG_RUN = 40;

    typedef struct {
        logic [sllx_pkg::KIND_W-1:0] kind;
        logic [LEN_W-1:0]            len;
        logic [LINE_W-1:0]           line;
        logic [OFFS_W-1:0]           offs;
        logic                        fin;
    } t_token;

    typedef struct {
        logic [7:0] b;
        logic       eos;
        bit         burst;
        bit         settle;
    } t_src_item;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [7:0]                  i_source_byte = 8'h00;
    logic                        i_end_of_source = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [sllx_pkg::KIND_W-1:0] o_token_kind;
    logic [LEN_W-1:0]            o_token_length;
    logic [LINE_W-1:0]           o_start_line;
    logic [OFFS_W-1:0]           o_start_offset;
    logic                        o_final_token;

    source_lexer_byte_stream #(
        .LENGTH_BITS(LEN_W),
        .LINE_BITS(LINE_W),
        .OFFSET_BITS(OFFS_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_source_byte(i_source_byte),
        .i_end_of_source(i_end_of_source),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_token_kind(o_token_kind),
        .o_token_length(o_token_length),
        .o_start_line(o_start_line),
        .o_start_offset(o_start_offset),
        .o_final_token(o_final_token)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predicted lexer state.
    logic [sllx_pkg::MODE_W-1:0] lx_mode;
    logic [LEN_W-1:0]            tok_len;
    logic [LINE_W-1:0]           tok_line;
    logic [OFFS_W-1:0]           tok_offs;
    logic [LINE_W-1:0]           cur_line;
    logic [OFFS_W-1:0]           byte_pos;
    logic [7:0]                  id_chars [sllx_pkg::KW_CHARS];
    bit                          src_done;

    t_token    step_toks [$];
    t_token    tokens_due [$];
    t_src_item src_q [$];

    int  due_total = 0;
    int  got_total = 0;
    int  sent_total = 0;
    int  stim_total = 0;
    int  stim_bytes = 0;
    int  err_count = 0;
    int  send_gap = 0;
    int  out_stall = 0;
    bit  cur_burst = 0;
    bit  settle_next = 0;
    bit  calm = 0;
    t_token want;

    function automatic string kw_word(input int k);
        case (k)
            0: return "break";
            1: return "continue";
            2: return "elif";
            3: return "else";
            4: return "fn";
            5: return "i8";
            6: return "i64";
            7: return "if";
            8: return "nil";
            9: return "rep";
            10: return "return";
            11: return "st";
            default: return "while";
        endcase
    endfunction

    function automatic bit digit_ch(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit word_ch(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
    endfunction

    function automatic bit lone_punct(input logic [7:0] b);
        string set;
        set = ":;{}=+/*%()[].,";
        for (int i = 0; i < set.len(); i++) begin
            if (set[i] == b) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void lexer_clear();
        lx_mode = sllx_pkg::M_IDLE;
        tok_len = '0;
        tok_line = LINE_W'(1);
        tok_offs = '0;
        cur_line = LINE_W'(1);
        byte_pos = '0;
        for (int i = 0; i < sllx_pkg::KW_CHARS; i++) id_chars[i] = 8'h00;
        src_done = 1'b0;
    endfunction

    function automatic void emit(input logic [sllx_pkg::KIND_W-1:0] kind,
                                 input logic [LEN_W-1:0] len,
                                 input logic [LINE_W-1:0] line,
                                 input logic [OFFS_W-1:0] offs);
        t_token t;
        t.kind = kind;
        t.len = len;
        t.line = line;
        t.offs = offs;
        t.fin = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic logic [sllx_pkg::KIND_W-1:0] ident_kind();
        string w;
        bit hit;
        if (tok_len > sllx_pkg::KW_CHARS) return sllx_pkg::KIND_IDENT;
        for (int k = 0; k < sllx_pkg::KW_COUNT; k++) begin
            w = kw_word(k);
            hit = (w.len() == tok_len);
            for (int i = 0; i < w.len() && hit; i++) begin
                if (w[i] != id_chars[i]) hit = 1'b0;
            end
            if (hit) return sllx_pkg::KIND_KW0 + sllx_pkg::KIND_W'(k);
        end
        return sllx_pkg::KIND_IDENT;
    endfunction

    function automatic void flush_pending();
        case (lx_mode)
            sllx_pkg::M_NUM: emit(sllx_pkg::KIND_NUMBER, tok_len, tok_line, tok_offs);
            sllx_pkg::M_IDENT: emit(ident_kind(), tok_len, tok_line, tok_offs);
            sllx_pkg::M_STR, sllx_pkg::M_AMP, sllx_pkg::M_BAR:
                emit(sllx_pkg::KIND_UNKNOWN, tok_len, tok_line, tok_offs);
            sllx_pkg::M_BANG, sllx_pkg::M_LT, sllx_pkg::M_GT, sllx_pkg::M_MINUS:
                emit(sllx_pkg::KIND_PUNCT, tok_len, tok_line, tok_offs);
            default: ;
        endcase
        lx_mode = sllx_pkg::M_IDLE;
    endfunction

    function automatic void open_token(input logic [7:0] b, input logic [OFFS_W-1:0] pos);
        logic [sllx_pkg::MODE_W-1:0] m;
        m = sllx_pkg::M_IDLE;
        if (digit_ch(b)) m = sllx_pkg::M_NUM;
        else if (word_ch(b)) m = sllx_pkg::M_IDENT;
        else if (b == sllx_pkg::CH_QUOTE) m = sllx_pkg::M_STR;
        else if (b == sllx_pkg::CH_BANG) m = sllx_pkg::M_BANG;
        else if (b == sllx_pkg::CH_AMP) m = sllx_pkg::M_AMP;
        else if (b == sllx_pkg::CH_BAR) m = sllx_pkg::M_BAR;
        else if (b == sllx_pkg::CH_LT) m = sllx_pkg::M_LT;
        else if (b == sllx_pkg::CH_GT) m = sllx_pkg::M_GT;
        else if (b == sllx_pkg::CH_MINUS) m = sllx_pkg::M_MINUS;

        if (m != sllx_pkg::M_IDLE) begin
            lx_mode = m;
            tok_len = LEN_W'(1);
            tok_line = cur_line;
            tok_offs = pos;
            id_chars[0] = b;
        end else if (b == sllx_pkg::CH_NL) begin
            emit(sllx_pkg::KIND_DELIM, LEN_W'(1), cur_line, pos);
            if (cur_line != '1) cur_line = cur_line + 1'b1;
        end else if (b == sllx_pkg::CH_SP || b == sllx_pkg::CH_CR) begin
            emit(sllx_pkg::KIND_DELIM, LEN_W'(1), cur_line, pos);
        end else if (lone_punct(b)) begin
            emit(sllx_pkg::KIND_PUNCT, LEN_W'(1), cur_line, pos);
        end else begin
            emit(sllx_pkg::KIND_UNKNOWN, LEN_W'(1), cur_line, pos);
        end
    endfunction

    // Advances the predicted lexer by one byte and queues the tokens it yields.
    function automatic int lex_byte(input logic [7:0] b, input logic eos);
        logic [OFFS_W-1:0] pos;
        bit taken;
        bit ended;
        step_toks.delete();
        if (src_done) return 0;
        pos = byte_pos;
        taken = 1'b0;
        ended = 1'b0;
        if (b == sllx_pkg::CH_NUL) begin
            flush_pending();
            ended = 1'b1;
        end else begin
            case (lx_mode)
                sllx_pkg::M_NUM: begin
                    if (digit_ch(b)) begin
                        if (tok_len != '1) tok_len = tok_len + 1'b1;
                        taken = 1'b1;
                    end else flush_pending();
                end
                sllx_pkg::M_IDENT: begin
                    if (word_ch(b) || digit_ch(b)) begin
                        if (tok_len < sllx_pkg::KW_CHARS) id_chars[tok_len[2:0]] = b;
                        if (tok_len != '1) tok_len = tok_len + 1'b1;
                        taken = 1'b1;
                    end else flush_pending();
                end
                sllx_pkg::M_STR: begin
                    if (tok_len != '1) tok_len = tok_len + 1'b1;
                    taken = 1'b1;
                    if (b == sllx_pkg::CH_QUOTE) begin
                        emit(sllx_pkg::KIND_STRING, tok_len, tok_line, tok_offs);
                        lx_mode = sllx_pkg::M_IDLE;
                    end
                end
                sllx_pkg::M_BANG, sllx_pkg::M_LT, sllx_pkg::M_GT: begin
                    if (b == sllx_pkg::CH_EQ) taken = 1'b1; else flush_pending();
                end
                sllx_pkg::M_AMP: begin
                    if (b == sllx_pkg::CH_AMP) taken = 1'b1; else flush_pending();
                end
                sllx_pkg::M_BAR: begin
                    if (b == sllx_pkg::CH_BAR) taken = 1'b1; else flush_pending();
                end
                sllx_pkg::M_MINUS: begin
                    if (b == sllx_pkg::CH_GT) taken = 1'b1; else flush_pending();
                end
                default: ;
            endcase
            if (taken && lx_mode >= sllx_pkg::M_BANG) begin
                emit(sllx_pkg::KIND_PUNCT, LEN_W'(2), tok_line, tok_offs);
                lx_mode = sllx_pkg::M_IDLE;
            end
            if (!taken) open_token(b, pos);
            if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
            if (eos) begin
                flush_pending();
                ended = 1'b1;
            end
        end
        if (ended) begin
            src_done = 1'b1;
            if (step_toks.size() > 0) step_toks[step_toks.size() - 1].fin = 1'b1;
        end
        foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
        return step_toks.size();
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [7:0] pick_char(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    task automatic report_bad(input string what, input int idx, input logic [31:0] got,
                              input logic [31:0] exp_val);
        err_count++;
        $display("token %0d: %s got %0d, want %0d", idx, what, got, exp_val);
    endtask

    task automatic push_src(input logic [7:0] b, input logic eos, input bit burst);
        t_src_item it;
        it.b = b;
        it.eos = eos;
        it.burst = burst;
        it.settle = settle_next;
        settle_next = 1'b0;
        src_q.push_back(it);
        stim_total++;
        if (!burst) stim_bytes++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_src(s[i], 1'b0, 1'b0);
    endtask

    task automatic push_string_body(input int n, input bit burst);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                c = pick_char("ab xy\n;1Q");
            end else begin
                c = 8'($urandom_range(1, 255));
                while (c == sllx_pkg::CH_QUOTE) c = 8'($urandom_range(1, 255));
            end
            push_src(c, 1'b0, burst);
        end
    endtask

    task automatic add_random_token();
        int n;
        int k;
        string pairs;
        case ($urandom_range(0, 11))
            0: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) push_src(pick_char("0123456789"), 1'b0, 1'b0);
            end
            1, 2: begin
                n = $urandom_range(1, 12);
                push_src(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"),
                         1'b0, 1'b0);
                for (int i = 1; i < n; i++)
                    push_src(pick_char("abcdefilnorstuwxyzAZ_0123456789"), 1'b0, 1'b0);
            end
            3: begin
                push_text(kw_word($urandom_range(0, sllx_pkg::KW_COUNT - 1)));
                if ($urandom_range(0, 3) == 0) push_src(pick_char("a_4Z"), 1'b0, 1'b0);
            end
            4: begin
                push_src(sllx_pkg::CH_QUOTE, 1'b0, 1'b0);
                push_string_body($urandom_range(0, 10), 1'b0);
                push_src(sllx_pkg::CH_QUOTE, 1'b0, 1'b0);
            end
            5: begin
                pairs = "!=&&||<=>=->";
                k = 2 * $urandom_range(0, 5);
                push_src(pairs[k], 1'b0, 1'b0);
                push_src(pairs[k + 1], 1'b0, 1'b0);
            end
            6: push_src(pick_char("!<>-&|"), 1'b0, 1'b0);
            7: push_src(pick_char(":;{}=+/*%()[].,"), 1'b0, 1'b0);
            8: begin
                k = $urandom_range(0, 2);
                push_src(k == 0 ? sllx_pkg::CH_SP : (k == 1 ? sllx_pkg::CH_CR : sllx_pkg::CH_NL),
                         1'b0, 1'b0);
            end
            9: push_src(8'($urandom_range(1, 255)), 1'b0, 1'b0);
            default: push_src(sllx_pkg::CH_SP, 1'b0, 1'b0);
        endcase
    endtask

    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) calm <= !calm;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
            lexer_clear();
        end else if (!(i_in_valid && !o_in_ready)) begin
            if (i_in_valid) begin
                due_total = due_total + lex_byte(i_source_byte, i_end_of_source);
                sent_total++;
                send_gap = cur_burst ? 0 : pick_gap();
            end
            if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap = send_gap - 1;
            end else if (src_q.size() != 0 && !(src_q[0].settle && got_total != due_total)) begin
                i_in_valid <= 1'b1;
                i_source_byte <= src_q[0].b;
                i_end_of_source <= src_q[0].eos;
                cur_burst = src_q[0].burst;
                void'(src_q.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got_total <= got_total + 1;
                if (tokens_due.size() == 0) begin
                    report_bad("unexpected token, kind", got_total, 32'(o_token_kind), 32'd0);
                end else begin
                    want = tokens_due.pop_front();
                    if (o_token_kind !== want.kind)
                        report_bad("kind", got_total, 32'(o_token_kind), 32'(want.kind));
                    if (o_token_length !== want.len)
                        report_bad("length", got_total, 32'(o_token_length), 32'(want.len));
                    if (o_start_line !== want.line)
                        report_bad("line", got_total, 32'(o_start_line), 32'(want.line));
                    if (o_start_offset !== want.offs)
                        report_bad("offset", got_total, 32'(o_start_offset), 32'(want.offs));
                    if (o_final_token !== want.fin)
                        report_bad("final flag", got_total, 32'(o_final_token), 32'(want.fin));
                end
            end
            if (out_stall > 0) begin
                i_out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) out_stall <= pick_gap();
            end
        end
    end

    logic [7:0] end_ch;
    logic       end_flag;
    bit         long_done = 0;

    initial begin
        push_text("7x\"\n\"!=&&||<=>=->&|<");
        push_src(8'hFF, 1'b0, 1'b0);
        push_src(8'h01, 1'b0, 1'b0);
        push_src(sllx_pkg::CH_CR, 1'b0, 1'b0);
        push_src(sllx_pkg::CH_NL, 1'b0, 1'b0);

        settle_next = 1'b1;
        while (stim_bytes < 460) begin
            if (!long_done && stim_bytes > 230) begin
                // One long string is sent with no gaps between its bytes.
                push_src(sllx_pkg::CH_QUOTE, 1'b0, 1'b1);
                push_string_body(LONG_RUN, 1'b1);
                push_src(sllx_pkg::CH_QUOTE, 1'b0, 1'b0);
                long_done = 1'b1;
            end
            if ($urandom_range(0, 29) == 0) settle_next = 1'b1;
            add_random_token();
        end

        case ($urandom_range(0, 4))
            0: push_src(sllx_pkg::CH_NUL, 1'b0, 1'b0);
            1: begin
                end_ch = 8'($urandom_range(1, 255));
                push_src(end_ch, 1'b1, 1'b0);
            end
            2: push_src(sllx_pkg::CH_SP, 1'b1, 1'b0);
            3: begin
                push_src(sllx_pkg::CH_QUOTE, 1'b0, 1'b0);
                push_text("ab\ncd");
                if ($urandom_range(0, 1) == 0) push_src(sllx_pkg::CH_NUL, 1'b0, 1'b0);
                else push_src("z", 1'b1, 1'b0);
            end
            default: begin
                push_src(sllx_pkg::CH_SP, 1'b0, 1'b0);
                end_flag = 1'($urandom_range(0, 1));
                push_src(sllx_pkg::CH_NUL, end_flag, 1'b0);
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            end_ch = 8'($urandom_range(0, 255));
            end_flag = 1'($urandom_range(0, 1));
            push_src(end_ch, end_flag, 1'b0);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_total != stim_total) @(posedge i_clk);
        while (got_total != due_total) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tokens_due.size() != 0)
            report_bad("tokens never produced, count", got_total, 32'd0,
                       32'(tokens_due.size()));
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sllx_pkg.sv
rtl/sllx_core.sv
rtl/sllx_fifo.sv
rtl/source_lexer_byte_stream.sv
rtl/sllx_chk.sv
tb/tb_source_lexer_byte_stream.sv
